>>> rtl/pms_pkg.sv
// Shared types and constants for the particle motion step block.
// Used by every module under rtl; depends on nothing else.
package pms_pkg;

  localparam int SLOT_W = 8;
  localparam int ADDR_W = 5;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_STEP   = 1'b1;

  localparam logic [2:0] REG_SCALE_RATE    = 3'd0;
  localparam logic [2:0] REG_FRICTION_GAIN = 3'd1;
  localparam logic [2:0] REG_GRAVITY_ACCEL = 3'd2;
  localparam logic [2:0] REG_FRAME_RATE    = 3'd3;
  localparam logic [2:0] REG_FRAME_COUNT   = 3'd4;
  localparam logic [2:0] REG_START_ALPHA   = 3'd5;

  localparam logic [31:0] SCALE_RATE_RST    = 32'd0;
  localparam logic [15:0] FRICTION_GAIN_RST = 16'd32768;
  localparam logic [31:0] GRAVITY_ACCEL_RST = 32'd0;
  localparam logic [15:0] FRAME_RATE_RST    = 16'd256;
  localparam logic [7:0]  FRAME_COUNT_RST   = 8'd8;
  localparam logic [7:0]  START_ALPHA_RST   = 8'd255;

  localparam logic [15:0] TIMER_STEP   = 16'h0222;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic signed [26:0] WOBBLE_AMP = 27'sd59652324;

  localparam longint Q30_C1 = 64'sd1686629713;
  localparam longint Q30_C3 = 64'sd693598668;
  localparam longint Q30_C5 = 64'sd85569306;
  localparam longint Q30_C7 = 64'sd5026995;
  localparam longint Q30_C9 = 64'sd172272;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WOB,
    ST_WB
  } pms_state_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] scale;
    logic [15:0]        angle;
    logic [15:0]        spin;
    logic [15:0]        frame;
    logic [15:0]        timer;
    logic [7:0]         alpha;
  } pms_entry_t;

  typedef struct packed {
    logic signed [31:0] scale_rate;
    logic [15:0]        friction_gain;
    logic signed [31:0] gravity_accel;
    logic [15:0]        frame_rate;
    logic [7:0]         frame_count;
    logic [7:0]         start_alpha;
  } pms_cfg_t;

endpackage

>>> rtl/pms_store.sv
// Particle entry memory: one write port, one registered read port.
// Depends on pms_pkg for the entry layout.
module pms_store #(
  parameter int PARTICLES = 256,
  parameter int AW = 8
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output pms_pkg::pms_entry_t rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  pms_pkg::pms_entry_t wr_data
);

  pms_pkg::pms_entry_t mem [PARTICLES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/pms_sine.sv
// Wobble path: sine ROM lookup by timer, then scaling to 10 degrees.
// Two register stages; depends on pms_pkg for constants.
module pms_sine #(
  parameter int SINE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic [15:0] timer,
  output logic [15:0] wobble
);

  localparam int SW = $clog2(SINE_ENTRIES);

  function automatic longint quarter_sine(input longint x);
    longint t;
    longint t2;
    longint s;
    t  = x <<< 16;
    t2 = (t * t) >>> 30;
    s  = pms_pkg::Q30_C9;
    s  = pms_pkg::Q30_C7 - ((t2 * s) >>> 30);
    s  = pms_pkg::Q30_C5 - ((t2 * s) >>> 30);
    s  = pms_pkg::Q30_C3 - ((t2 * s) >>> 30);
    s  = pms_pkg::Q30_C1 - ((t2 * s) >>> 30);
    return (t * s) >>> 30;
  endfunction

  function automatic logic signed [16:0] sine_entry(input longint i);
    longint ph;
    longint q;
    longint x;
    longint s;
    ph = (i * 65536) / SINE_ENTRIES;
    q  = (ph >>> 14) & 3;
    x  = ph & 16'h3FFF;
    if ((q & 1) != 0) begin
      x = 16384 - x;
    end
    s = (quarter_sine(x) + 16384) >>> 15;
    if (s > 32768) begin
      s = 32768;
    end
    return ((q & 2) != 0) ? 17'(-s) : 17'(s);
  endfunction

  logic signed [16:0] sine_rom [SINE_ENTRIES];
  logic [32:0]        idx_full;
  logic [SW-1:0]      idx;
  logic signed [16:0] rom_q;
  logic signed [43:0] prod;
  logic signed [43:0] adj;
  logic [15:0]        delta;

  for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_rom
    localparam logic signed [16:0] ENTRY = sine_entry(longint'(gi));
    assign sine_rom[gi] = ENTRY;
  end

  assign idx_full = 33'(timer) * 33'(SINE_ENTRIES);
  assign idx      = idx_full[16 +: SW];

  always_ff @(posedge clk) begin
    rom_q <= sine_rom[idx];
    prod  <= rom_q * pms_pkg::WOBBLE_AMP;
  end

  // truncate toward zero
  assign adj    = prod + (prod[43] ? 44'sd1073741823 : 44'sd0);
  assign delta  = 16'(adj >>> 30);
  assign wobble = pms_pkg::QUARTER_TURN + delta;

endmodule

>>> rtl/pms_motion.sv
// Step update of one particle entry: friction products, saturating adds,
// frame hold and alpha fade. Depends on pms_pkg.
module pms_motion (
  input  logic                clk,
  input  pms_pkg::pms_cfg_t   cfg,
  input  pms_pkg::pms_entry_t cur,
  output pms_pkg::pms_entry_t nxt,
  output logic                alive
);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    return sat32(s);
  endfunction

  function automatic logic signed [31:0] round_q15(input logic signed [48:0] p);
    logic signed [48:0] r;
    r = p + 49'sd16384;
    return sat32(r[48:15]);
  endfunction

  logic signed [16:0] gain;
  logic signed [48:0] prod_x;
  logic signed [48:0] prod_y;
  logic signed [48:0] prod_z;
  logic [16:0]        frame_sum;
  logic [15:0]        frame_sat;
  logic               fade;
  logic [7:0]         alpha_half;

  assign gain = $signed({1'b0, cfg.friction_gain});

  always_ff @(posedge clk) begin
    prod_x <= cur.vel_x * gain;
    prod_y <= cur.vel_y * gain;
    prod_z <= cur.vel_z * gain;
  end

  assign frame_sum  = 17'(cur.frame) + 17'(cfg.frame_rate);
  assign frame_sat  = frame_sum[16] ? 16'hFFFF : frame_sum[15:0];
  assign fade       = frame_sat[15:8] >= cfg.frame_count;
  assign alpha_half = {1'b0, cur.alpha[7:1]};

  always_comb begin
    nxt       = cur;
    nxt.pos_x = sat_add(cur.pos_x, cur.vel_x);
    nxt.pos_y = sat_add(cur.pos_y, cur.vel_y);
    nxt.pos_z = sat_add(cur.pos_z, cur.vel_z);
    nxt.vel_x = round_q15(prod_x);
    nxt.vel_y = sat_add(round_q15(prod_y), cfg.gravity_accel);
    nxt.vel_z = round_q15(prod_z);
    nxt.scale = sat_add(cur.scale, cfg.scale_rate);
    nxt.angle = cur.angle + cur.spin;
    nxt.timer = cur.timer + pms_pkg::TIMER_STEP;
    nxt.frame = frame_sat;
    alive     = 1'b1;
    if (fade) begin
      nxt.frame = (cfg.frame_count != 8'd0) ? {cfg.frame_count - 8'd1, 8'h00} : 16'h0000;
      nxt.alpha = alpha_half;
      alive     = alpha_half != 8'd0;
    end
  end

endmodule

>>> rtl/particle_motion_step_top.sv
// Top level of the particle motion step block: control sequencer,
// configuration registers and result register. Depends on pms_pkg,
// pms_store, pms_sine and pms_motion.
//
// Usage: items enter on in_valid/in_stall, results leave on
// out_valid/out_stall; a beat moves when valid is high and stall low.
// A create beat writes one entry and reports it; a step beat reads the
// entry, updates it and writes it back. One result beat per input beat.
// out_valid rises once the item has passed ST_MUL, ST_WOB and ST_WB,
// and ST_WB waits while the output register is held. The item walks the
// store read, the friction and sine-ROM cycle, the wobble multiply and
// the write-back; the next read is issued only after that write-back.
// The next item is taken while a result waits in the output register.
// If the receiver stalls, the write-back of the following item waits
// until the output register is free; in_stall stays high meanwhile.
// Reset clears the sequencer, the output valid and the configuration
// registers to their defaults; the particle store is not cleared, and an
// entry must be created before it is stepped. The user must write
// configuration over the APB port while the block is idle; not checked.
module particle_motion_step_top #(
  parameter int PARTICLES = 256,
  parameter int SINE_ENTRIES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pms_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic [7:0]                 slot,
  input  logic signed [31:0]         pos_x_in,
  input  logic signed [31:0]         pos_y_in,
  input  logic signed [31:0]         pos_z_in,
  input  logic signed [31:0]         vel_x_in,
  input  logic signed [31:0]         vel_y_in,
  input  logic signed [31:0]         vel_z_in,
  input  logic signed [31:0]         scale_in,
  input  logic [15:0]                angle_in,
  input  logic signed [15:0]         spin_in,
  input  logic [15:0]                frame_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 slot_out,
  output logic                       alive,
  output logic signed [31:0]         pos_x_out,
  output logic signed [31:0]         pos_y_out,
  output logic signed [31:0]         pos_z_out,
  output logic signed [31:0]         scale_out,
  output logic [15:0]                angle_out,
  output logic [15:0]                wobble_out,
  output logic [7:0]                 frame_out,
  output logic [7:0]                 alpha_out
);

  localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int SLOTS = 1 << pms_pkg::SLOT_W;

  pms_pkg::pms_state_t state;
  pms_pkg::pms_state_t state_next;

  logic [31:0] scale_rate;
  logic [15:0] friction_gain;
  logic [31:0] gravity_accel;
  logic [15:0] frame_rate;
  logic [7:0]  frame_count;
  logic [7:0]  start_alpha;
  pms_pkg::pms_cfg_t cfg;

  logic [AW-1:0] slot_map [SLOTS];
  logic          cfg_wr;
  logic          accept;
  logic          out_free;
  logic          wr_en;
  logic          cmd_q;
  logic [7:0]    slot_q;
  logic [AW-1:0] k_q;

  pms_pkg::pms_entry_t cr_entry;
  pms_pkg::pms_entry_t cur;
  pms_pkg::pms_entry_t step_entry;
  pms_pkg::pms_entry_t wr_entry;
  logic                step_alive;
  logic [15:0]         wobble;

  for (genvar gi = 0; gi < SLOTS; gi++) begin : g_slot
    assign slot_map[gi] = AW'(gi % PARTICLES);
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_rate    <= pms_pkg::SCALE_RATE_RST;
      friction_gain <= pms_pkg::FRICTION_GAIN_RST;
      gravity_accel <= pms_pkg::GRAVITY_ACCEL_RST;
      frame_rate    <= pms_pkg::FRAME_RATE_RST;
      frame_count   <= pms_pkg::FRAME_COUNT_RST;
      start_alpha   <= pms_pkg::START_ALPHA_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        pms_pkg::REG_SCALE_RATE:    scale_rate    <= pwdata;
        pms_pkg::REG_FRICTION_GAIN: friction_gain <= pwdata[15:0];
        pms_pkg::REG_GRAVITY_ACCEL: gravity_accel <= pwdata;
        pms_pkg::REG_FRAME_RATE:    frame_rate    <= pwdata[15:0];
        pms_pkg::REG_FRAME_COUNT:   frame_count   <= pwdata[7:0];
        pms_pkg::REG_START_ALPHA:   start_alpha   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      pms_pkg::REG_SCALE_RATE:    prdata = scale_rate;
      pms_pkg::REG_FRICTION_GAIN: prdata = {16'd0, friction_gain};
      pms_pkg::REG_GRAVITY_ACCEL: prdata = gravity_accel;
      pms_pkg::REG_FRAME_RATE:    prdata = {16'd0, frame_rate};
      pms_pkg::REG_FRAME_COUNT:   prdata = {24'd0, frame_count};
      pms_pkg::REG_START_ALPHA:   prdata = {24'd0, start_alpha};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg.scale_rate    = scale_rate;
  assign cfg.friction_gain = friction_gain;
  assign cfg.gravity_accel = gravity_accel;
  assign cfg.frame_rate    = frame_rate;
  assign cfg.frame_count   = frame_count;
  assign cfg.start_alpha   = start_alpha;

  // sequencer
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  always_comb begin
    state_next = state;
    case (state)
      pms_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = pms_pkg::ST_MUL;
        end
      end
      pms_pkg::ST_MUL: state_next = pms_pkg::ST_WOB;
      pms_pkg::ST_WOB: state_next = pms_pkg::ST_WB;
      pms_pkg::ST_WB: begin
        if (out_free) begin
          state_next = pms_pkg::ST_IDLE;
        end
      end
      default: state_next = pms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    wr_en    = 1'b0;
    case (state)
      pms_pkg::ST_IDLE: in_stall = 1'b0;
      pms_pkg::ST_WB:   wr_en    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q          <= cmd;
      slot_q         <= slot;
      k_q            <= slot_map[slot];
      cr_entry.pos_x <= pos_x_in;
      cr_entry.pos_y <= pos_y_in;
      cr_entry.pos_z <= pos_z_in;
      cr_entry.vel_x <= vel_x_in;
      cr_entry.vel_y <= vel_y_in;
      cr_entry.vel_z <= vel_z_in;
      cr_entry.scale <= scale_in;
      cr_entry.angle <= angle_in;
      cr_entry.spin  <= spin_in;
      cr_entry.frame <= frame_in;
      cr_entry.timer <= 16'd0;
      cr_entry.alpha <= start_alpha;
    end
  end

  pms_store #(
    .PARTICLES (PARTICLES),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (slot_map[slot]),
    .rd_data (cur),
    .wr_en   (wr_en),
    .wr_addr (k_q),
    .wr_data (wr_entry)
  );

  pms_sine #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_sine (
    .clk    (clk),
    .timer  (cur.timer),
    .wobble (wobble)
  );

  pms_motion u_motion (
    .clk   (clk),
    .cfg   (cfg),
    .cur   (cur),
    .nxt   (step_entry),
    .alive (step_alive)
  );

  assign wr_entry = (cmd_q == pms_pkg::CMD_CREATE) ? cr_entry : step_entry;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr_en) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_out  <= slot_q;
      pos_x_out <= wr_entry.pos_x;
      pos_y_out <= wr_entry.pos_y;
      pos_z_out <= wr_entry.pos_z;
      scale_out <= wr_entry.scale;
      angle_out <= wr_entry.angle;
      frame_out <= wr_entry.frame[15:8];
      alpha_out <= wr_entry.alpha;
      if (cmd_q == pms_pkg::CMD_CREATE) begin
        alive      <= 1'b1;
        wobble_out <= 16'd0;
      end else begin
        alive      <= step_alive;
        wobble_out <= wobble;
      end
    end
  end

endmodule
